// ----- rtl/core/mmpp_pkg.sv -----
// Package of the min/max peak pyramid: sizes, field types and the structs
// that travel along the row of level cells. No dependencies.
package mmpp_pkg;

  localparam int unsigned LEVELS        = 16;
  localparam int unsigned SAMPLE_WIDTH  = 16;
  localparam int unsigned COUNTER_WIDTH = 32;
  localparam int unsigned LEVEL_WIDTH   = 5;
  localparam int unsigned INDEX_WIDTH   = 31;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNTER_WIDTH-1:0]       count_t;
  typedef logic [LEVEL_WIDTH-1:0]         level_t;
  typedef logic [INDEX_WIDTH-1:0]         index_t;

  // One reported block as held by a cell.
  typedef struct packed {
    level_t  level;
    logic    done;
    index_t  index;
    sample_t lo;
    sample_t hi;
  } rep_t;

  // Selection chain passed from cell to cell, lowest level first.
  typedef struct packed {
    logic found;
    logic more;
    rep_t data;
  } sel_t;

endpackage

// ----- rtl/core/mmpp_if.sv -----
// Request channel interfaces of the min/max peak pyramid.
// Depends on mmpp_pkg.
interface mmpp_in_if;
  logic                 valid;
  logic                 ready;
  mmpp_pkg::sample_t    sample;
  logic                 last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mmpp_out_if;
  logic                 valid;
  logic                 ready;
  mmpp_pkg::level_t     level;
  mmpp_pkg::index_t     block_index;
  mmpp_pkg::sample_t    block_min;
  mmpp_pkg::sample_t    block_max;
  logic                 last_of_run;

  modport source (output valid, output level, output block_index, output block_min,
                  output block_max, output last_of_run, input ready);
  modport sink   (input valid, input level, input block_index, input block_min,
                  input block_max, input last_of_run, output ready);
endinterface

// ----- rtl/core/mmpp_cell.sv -----
// One level cell: running minimum and maximum of the current block, its
// pending and report flags, and its stage of the selection chain. Uses mmpp_pkg.
module mmpp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mmpp_pkg::sample_t sample_i,
  input  logic              last_i,
  input  logic              done_i,
  input  logic              big_i,
  input  mmpp_pkg::level_t  level_i,
  input  mmpp_pkg::index_t  index_i,
  input  logic              emit_i,
  input  mmpp_pkg::sel_t    chain_i,
  output mmpp_pkg::sel_t    chain_o
);

  mmpp_pkg::sample_t min_q, max_q, min_d, max_d;
  logic              pend_q, rep_q, done_q;
  logic              take, pop;
  mmpp_pkg::rep_t    mine;

  always_comb begin
    min_d = (!pend_q || (sample_i < min_q)) ? sample_i : min_q;
    max_d = (!pend_q || (sample_i > max_q)) ? sample_i : max_q;
    take  = rep_q & ~chain_i.found;
    pop   = take & emit_i;
    mine.level = level_i;
    mine.done  = done_q;
    mine.index = index_i;
    mine.lo    = min_q;
    mine.hi    = max_q;
    chain_o.found = chain_i.found | rep_q;
    chain_o.more  = chain_i.more | (chain_i.found & rep_q);
    chain_o.data  = take ? mine : chain_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      rep_q  <= 1'b0;
    end else if (en_i) begin
      pend_q <= ~last_i & ~done_i;
      rep_q  <= done_i | (last_i & big_i);
    end else if (pop) begin
      rep_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      min_q  <= min_d;
      max_q  <= max_d;
      done_q <= done_i;
    end
  end

endmodule

// ----- rtl/core/min_max_peak_pyramid.sv -----
// Top level of the min/max peak pyramid: sample counter, row of level cells
// and output register. Uses mmpp_pkg, mmpp_if and mmpp_cell.
//
// Each request on in_i carries one signed sample and a flag for the last
// sample of a stream. For every level L the block tracks the minimum and
// maximum over blocks of 2^L samples and sends one request on out_o per
// completed block, lowest level first; the last sample of a stream also
// flushes the partial blocks of every level whose size fits the stream.
// last_of_run marks the final result caused by one input.
// When a sample is taken, all cells fold it in. Its n results then leave the
// cell row one per cycle while the receiver does not stall, through a
// priority chain into the output register; each result waits in its cell,
// marked by the report flag, until it is registered. The next sample is
// accepted once every result of the previous one has reached the output
// register. If the receiver stalls, the output register holds its result and
// the remaining results wait in the cells. Reset clears the counter, the
// pending and report flags of all cells and the output valid flag.
module min_max_peak_pyramid (
  input logic       clk_i,
  input logic       rst_ni,
  mmpp_in_if.sink   in_i,
  mmpp_out_if.source out_o
);

  localparam int unsigned CW = mmpp_pkg::COUNTER_WIDTH;

  mmpp_pkg::count_t cnt_q, cnt_d, snap_q, cnt_nx;
  logic             advance, accept, emit;
  logic             out_valid_q;
  mmpp_pkg::rep_t   out_q, out_d;
  logic             out_last_q;
  mmpp_pkg::sel_t   chain [mmpp_pkg::LEVELS+1];
  mmpp_pkg::sel_t   top_sel;

  assign advance   = (cnt_q != '1);
  assign cnt_nx    = advance ? (cnt_q + CW'(1)) : cnt_q;
  assign accept    = in_i.valid & in_i.ready;
  assign top_sel   = chain[mmpp_pkg::LEVELS];
  assign in_i.ready = ~top_sel.found;
  assign emit      = top_sel.found & (~out_valid_q | out_o.ready);
  assign cnt_d     = in_i.last_sample ? '0 : cnt_nx;
  assign chain[0]  = '0;

  for (genvar i = 0; i < mmpp_pkg::LEVELS; i++) begin : g_level
    logic             low_zero, big;
    mmpp_pkg::index_t idx;

    if (i + 1 < CW) begin : g_fit
      assign low_zero = (cnt_nx[i:0] == '0);
      assign big      = |cnt_nx[CW-1:i+1];
      assign idx      = mmpp_pkg::INDEX_WIDTH'(snap_q >> (i + 1));
    end else begin : g_over
      assign low_zero = (cnt_nx == '0);
      assign big      = 1'b0;
      assign idx      = '0;
    end

    mmpp_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .sample_i (in_i.sample),
      .last_i   (in_i.last_sample),
      .done_i   (advance & low_zero),
      .big_i    (big),
      .level_i  (mmpp_pkg::LEVEL_WIDTH'(i + 1)),
      .index_i  (idx),
      .emit_i   (emit),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1])
    );
  end

  always_comb begin
    out_d = top_sel.data;
    if (top_sel.data.done) begin
      out_d.index = top_sel.data.index - mmpp_pkg::INDEX_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snap_q <= cnt_nx;
    end
    if (emit) begin
      out_q      <= out_d;
      out_last_q <= ~top_sel.more;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.level       = out_q.level;
  assign out_o.block_index = out_q.index;
  assign out_o.block_min   = out_q.lo;
  assign out_o.block_max   = out_q.hi;
  assign out_o.last_of_run = out_last_q;

endmodule

// ----- rtl/core/mmpp_checker.sv -----
// Port checker of the min/max peak pyramid, bound to the top level.
// Uses mmpp_pkg.
module mmpp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input mmpp_pkg::level_t  out_level_i,
  input logic              out_last_i
);

  // A stalled result stays on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request withdrawn while stalled");

  // Taking new samples implies every earlier result has been queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("input ready while results of a run remain");

  // A run continues without a gap after a taken result that is not its last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a run of results");

  // Levels rise within a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_level_i > $past(out_level_i))
    else $error("levels out of order within a run");

  // After a sample is taken, the input is ready again only while the output is idle or offers the last result of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i || out_last_i || !in_ready_i)
    else $error("input taken while a run was still in progress");

endmodule

bind min_max_peak_pyramid mmpp_checker u_mmpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_level_i (out_o.level),
  .out_last_i  (out_o.last_of_run)
);
